FILE: rtl/zcj_pkg.sv
`default_nettype none
package zcj_pkg;

  localparam int RAW_W          = 14;
  localparam int SMP_W          = 15;
  localparam int AVG_W          = 15;
  localparam int QMAG_W         = 14;
  localparam int THR_W          = 15;
  localparam int CNT_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 15;
  localparam int WINDOW_LEN_DEF = 8;
  localparam int NEAR_BAND      = 50;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE  = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } zcj_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              clear;
    logic              neg;
    logic [QMAG_W-1:0] mag;
  } zcj_quot_t;

endpackage
`default_nettype wire

FILE: rtl/zcj_if.sv
`default_nettype none
interface zcj_in_if import zcj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [RAW_W-1:0] raw_sample;

  modport source (output valid, opcode, raw_sample, input ready);
  modport sink   (input valid, opcode, raw_sample, output ready);
endinterface

interface zcj_out_if import zcj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] smoothed_value;
  logic                    rising_cross;
  logic                    falling_cross;
  logic                    near_zero;
  logic [CNT_W-1:0]        jump_total;

  modport source (output valid, smoothed_value, rising_cross, falling_cross, near_zero,
                  jump_total, input ready);
  modport sink   (input valid, smoothed_value, rising_cross, falling_cross, near_zero,
                  jump_total, output ready);
endinterface
`default_nettype wire

FILE: rtl/zero_crossing_jump_counter_unit.sv
// Throughput: one word per cycle while out_ch.ready stays high; four register stages
// (input, window sum, reciprocal multiply, crossing logic and output), each stalling
// only when full and the next stage cannot take its word.
// Reset: synchronous, active-low rst_n clears the configuration, the window,
// the running sum, the average history, the extremum and the jump count.
`default_nettype none
module zero_crossing_jump_counter_unit import zcj_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  zcj_in_if.sink                     in_ch,
  zcj_out_if.source                  out_ch
);

  localparam int SUM_W = SMP_W + $clog2(WINDOW_LEN);

  logic signed [RAW_W-1:0] baseline_r;
  logic [THR_W-1:0]        threshold_r;
  zcj_ctl_t                ctl2;
  logic signed [SUM_W-1:0] sum2;
  zcj_quot_t               quot3;
  logic                    s3_rdy;
  logic                    s4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r  <= '0;
      threshold_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASELINE:  baseline_r  <= $signed(cfg_data[RAW_W-1:0]);
        REG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  zcj_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .baseline (baseline_r),
    .s3_rdy   (s3_rdy),
    .ctl_o    (ctl2),
    .sum_o    (sum2)
  );

  zcj_divider #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl2),
    .sum_i  (sum2),
    .s4_rdy (s4_rdy),
    .s3_rdy (s3_rdy),
    .quot_o (quot3)
  );

  zcj_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .quot_i    (quot3),
    .threshold (threshold_r),
    .s4_rdy    (s4_rdy),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/zcj_window.sv
`default_nettype none
module zcj_window import zcj_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int SUM_W      = SMP_W + $clog2(WINDOW_LEN)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  zcj_in_if.sink                       in_ch,
  input  wire logic signed [RAW_W-1:0] baseline,
  input  wire logic                    s3_rdy,
  output      zcj_ctl_t                ctl_o,
  output      logic signed [SUM_W-1:0] sum_o
);

  logic                    v1_r;
  logic                    op1_r;
  logic signed [RAW_W-1:0] raw1_r;
  logic                    v2_r;
  logic                    clr2_r;
  logic signed [SMP_W-1:0] win_r [WINDOW_LEN];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SMP_W-1:0] centered;
  logic                    rdy2;
  logic                    adv1;
  logic                    rdy1;

  assign rdy2     = !v2_r || s3_rdy;
  assign adv1     = v1_r && rdy2;
  assign rdy1     = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  assign centered = $signed({raw1_r[RAW_W-1], raw1_r}) - $signed({baseline[RAW_W-1], baseline});
  assign sum_nxt  = sum_r - SUM_W'(win_r[0]) + SUM_W'(centered);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      clr2_r <= 1'b0;
      sum_r  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (in_ch.valid && rdy1) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        v2_r   <= 1'b1;
        clr2_r <= op1_r;
        if (op1_r) begin
          sum_r <= '0;
          for (int i = 0; i < WINDOW_LEN; i++) begin
            win_r[i] <= '0;
          end
        end else begin
          sum_r <= sum_nxt;
          for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[WINDOW_LEN-1] <= centered;
        end
      end else if (s3_rdy) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy1) begin
      op1_r  <= in_ch.opcode;
      raw1_r <= in_ch.raw_sample;
    end
  end

  assign ctl_o.valid = v2_r;
  assign ctl_o.clear = clr2_r;
  assign sum_o       = sum_r;

endmodule
`default_nettype wire

FILE: rtl/zcj_divider.sv
`default_nettype none
module zcj_divider import zcj_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int SUM_W      = SMP_W + $clog2(WINDOW_LEN)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire zcj_ctl_t                ctl_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  input  wire logic                    s4_rdy,
  output      logic                    s3_rdy,
  output      zcj_quot_t               quot_o
);

  // |sum| < 2^MAG_W; multiply by ceil(2^SH / N) gives the exact floor quotient
  localparam int     MAG_W  = SUM_W - 1;
  localparam int     SH     = MAG_W + $clog2(WINDOW_LEN);
  localparam int     PROD_W = MAG_W + SH + 1;
  localparam longint RECIP_L = ((64'sd1 <<< SH) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [SH:0] RECIP = (SH+1)'(RECIP_L);

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic              adv2;
  logic              v3_r;
  logic              clr3_r;
  logic              neg3_r;
  logic [QMAG_W-1:0] q3_r;

  assign mag    = sum_i[SUM_W-1] ? MAG_W'(-sum_i) : MAG_W'(sum_i);
  assign prod   = PROD_W'(mag) * PROD_W'(RECIP);
  assign s3_rdy = !v3_r || s4_rdy;
  assign adv2   = ctl_i.valid && s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv2) begin
      v3_r <= 1'b1;
    end else if (s4_rdy) begin
      v3_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      clr3_r <= ctl_i.clear;
      neg3_r <= sum_i[SUM_W-1];
      q3_r   <= prod[SH +: QMAG_W];
    end
  end

  assign quot_o.valid = v3_r;
  assign quot_o.clear = clr3_r;
  assign quot_o.neg   = neg3_r;
  assign quot_o.mag   = q3_r;

endmodule
`default_nettype wire

FILE: rtl/zcj_detect.sv
`default_nettype none
module zcj_detect import zcj_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire zcj_quot_t        quot_i,
  input  wire logic [THR_W-1:0] threshold,
  output      logic             s4_rdy,
  zcj_out_if.source             out_ch
);

  localparam logic signed [AVG_W-1:0] NEAR_HI = AVG_W'(NEAR_BAND);
  localparam logic signed [AVG_W-1:0] NEAR_LO = -NEAR_HI;

  logic                    ovalid_r;
  logic signed [AVG_W-1:0] avg_out_r;
  logic                    rise_r;
  logic                    fall_r;
  logic                    near_r;
  logic signed [AVG_W-1:0] prev_r;
  logic signed [AVG_W-1:0] ext_r;
  logic [CNT_W-1:0]        cnt_r;

  logic signed [AVG_W-1:0] avg;
  logic                    rise;
  logic                    fall;
  logic                    near;
  logic signed [AVG_W:0]   diff;
  logic [AVG_W:0]          swing;
  logic                    jump;
  logic signed [AVG_W-1:0] ext_mid;
  logic signed [AVG_W-1:0] ext_nxt;
  logic                    adv3;

  assign s4_rdy = !ovalid_r || out_ch.ready;
  assign adv3   = quot_i.valid && s4_rdy;

  assign avg   = quot_i.neg ? -$signed({1'b0, quot_i.mag}) : $signed({1'b0, quot_i.mag});
  assign rise  = (prev_r <= 0) && (avg > 0);
  assign fall  = !rise && (prev_r >= 0) && (avg < 0);
  assign near  = !rise && !fall && (avg > NEAR_LO) && (avg < NEAR_HI);
  assign diff  = $signed({ext_r[AVG_W-1], ext_r}) - $signed({avg[AVG_W-1], avg});
  assign swing = diff[AVG_W] ? (AVG_W+1)'(-diff) : (AVG_W+1)'(diff);
  assign jump  = rise && (swing > {1'b0, threshold}) && (cnt_r != COUNT_MAX);

  always_comb begin
    ext_mid = (rise || fall) ? avg : ext_r;
    ext_nxt = ext_mid;
    if (avg > ext_mid && avg > 0) begin
      ext_nxt = avg;
    end else if (avg < ext_mid && avg < 0) begin
      ext_nxt = avg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      prev_r   <= '0;
      ext_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (adv3) begin
        ovalid_r <= 1'b1;
        if (quot_i.clear) begin
          ext_r <= '0;
          cnt_r <= '0;
        end else begin
          prev_r <= avg;
          ext_r  <= ext_nxt;
          if (jump) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      if (quot_i.clear) begin
        avg_out_r <= '0;
        rise_r    <= 1'b0;
        fall_r    <= 1'b0;
        near_r    <= 1'b0;
      end else begin
        avg_out_r <= avg;
        rise_r    <= rise;
        fall_r    <= fall;
        near_r    <= near;
      end
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.smoothed_value = avg_out_r;
  assign out_ch.rising_cross   = rise_r;
  assign out_ch.falling_cross  = fall_r;
  assign out_ch.near_zero      = near_r;
  assign out_ch.jump_total     = cnt_r;

endmodule
`default_nettype wire

FILE: verif/zero_crossing_jump_counter_unit_tb.sv
`timescale 1ns / 1ps
module zero_crossing_jump_counter_unit_tb;
  import zcj_pkg::*;

  localparam int WIN         = WINDOW_LEN_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } zc_op_t;

  typedef struct {
    zc_op_t                  op;
    logic signed [RAW_W-1:0] raw;
  } accel_word_t;

  typedef struct {
    logic signed [AVG_W-1:0] avg;
    logic                    rise;
    logic                    fall;
    logic                    nearz;
    logic [CNT_W-1:0]        count;
    int                      stamp;
  } crossing_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  zcj_in_if  in_ch ();
  zcj_out_if out_ch ();

  zero_crossing_jump_counter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  accel_word_t sample_q[$];
  crossing_t   crossing_q[$];

  // predictor state
  int cfg_baseline = 0;
  int cfg_threshold = 0;
  int win_smp[WIN];
  int win_sum = 0;
  int prev_avg = 0;
  int extremum = 0;
  int jumps = 0;

  int cyc = 0;
  int in_gap = 0;
  int out_stall = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic in_idle = 1'b0;
  logic out_idle = 1'b0;

  int mismatch_cnt = 0;
  int words_in = 0;
  int rises_seen = 0;
  int falls_seen = 0;
  int peak_total = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic crossing_t smooth_and_count(zc_op_t op, logic signed [RAW_W-1:0] raw);
    crossing_t r;
    int centred;
    int avg_i;
    int swing;
    r = '{default: '0};
    if (op == OP_CLEAR) begin
      jumps    = 0;
      extremum = 0;
      win_sum  = 0;
      foreach (win_smp[i]) win_smp[i] = 0;
      return r;
    end
    centred = int'(raw) - cfg_baseline;
    win_sum = win_sum - win_smp[0] + centred;
    for (int i = 0; i < WIN - 1; i++) win_smp[i] = win_smp[i + 1];
    win_smp[WIN - 1] = centred;
    avg_i = win_sum / WIN;
    if (prev_avg <= 0 && avg_i > 0) begin
      r.rise = 1'b1;
      swing = (extremum > avg_i) ? extremum - avg_i : avg_i - extremum;
      if (swing > cfg_threshold && jumps < int'(COUNT_MAX)) jumps++;
      extremum = avg_i;
    end else if (prev_avg >= 0 && avg_i < 0) begin
      r.fall = 1'b1;
      extremum = avg_i;
    end else if (((avg_i < 0) ? -avg_i : avg_i) < NEAR_BAND) begin
      r.nearz = 1'b1;
    end
    if (avg_i > extremum && avg_i > 0) extremum = avg_i;
    else if (avg_i < extremum && avg_i < 0) extremum = avg_i;
    prev_avg = avg_i;
    r.avg   = avg_i[AVG_W-1:0];
    r.count = jumps[CNT_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : drv
    logic        fire;
    accel_word_t w;
    crossing_t   r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        r = smooth_and_count(zc_op_t'(in_ch.opcode), in_ch.raw_sample);
        r.stamp = cyc;
        crossing_q.push_back(r);
        words_in++;
        in_gap = in_idle ? $urandom_range(0, 15) : 0;
      end
      if (fire || !in_ch.valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          w = sample_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= w.op;
          in_ch.raw_sample <= w.raw;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin : mon
    crossing_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        // a word accepted at this very edge cannot be the one on the output
        if (crossing_q.size() == 0 || crossing_q[0].stamp == cyc) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0d] unexpected word: avg %0d rise %0b fall %0b near %0b total %0d",
                     cyc, out_ch.smoothed_value, out_ch.rising_cross, out_ch.falling_cross,
                     out_ch.near_zero, out_ch.jump_total);
        end else begin
          want = crossing_q.pop_front();
          if (out_ch.smoothed_value !== want.avg || out_ch.rising_cross !== want.rise ||
              out_ch.falling_cross !== want.fall || out_ch.near_zero !== want.nearz ||
              out_ch.jump_total !== want.count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("[%0d] mismatch: exp avg %0d rise %0b fall %0b near %0b total %0d",
                       cyc, want.avg, want.rise, want.fall, want.nearz, want.count);
            if (mismatch_cnt <= 10)
              $display("[%0d]           got avg %0d rise %0b fall %0b near %0b total %0d",
                       cyc, out_ch.smoothed_value, out_ch.rising_cross, out_ch.falling_cross,
                       out_ch.near_zero, out_ch.jump_total);
          end
          if (want.rise) rises_seen++;
          if (want.fall) falls_seen++;
          if (int'(out_ch.jump_total) > peak_total) peak_total = int'(out_ch.jump_total);
        end
        out_stall = out_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASELINE) cfg_baseline = int'(signed'(data[RAW_W-1:0]));
    else cfg_threshold = int'(data[THR_W-1:0]);
  endtask

  task automatic push_sample(int v);
    accel_word_t w;
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    w.op  = OP_SAMPLE;
    w.raw = v[RAW_W-1:0];
    sample_q.push_back(w);
  endtask

  task automatic push_clear();
    accel_word_t w;
    w.op  = OP_CLEAR;
    w.raw = RAW_W'($urandom_range(0, 16383));
    sample_q.push_back(w);
  endtask

  // waits until every word has gone through, then lets the pipeline settle
  task automatic drain();
    while (sample_q.size() != 0 || in_ch.valid || crossing_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly square-ish swings around the baseline, some raw noise, rare clears
  task automatic queue_random(int n);
    int left;
    int pick;
    int amp;
    int half;
    int reps;
    int jit;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_clear();
        left--;
      end else if (pick < 24) begin
        repeat ($urandom_range(1, 6)) begin
          push_sample(int'($urandom_range(0, 16383)) - 8192);
          left--;
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       amp = $urandom_range(0, 120);
          1:       amp = $urandom_range(100, 2000);
          default: amp = $urandom_range(2000, 8191);
        endcase
        half = $urandom_range(1, 12);
        reps = $urandom_range(1, 4);
        jit  = amp / 8 + 1;
        repeat (reps) begin
          for (int s = 1; s >= -1; s -= 2) begin
            repeat (half) begin
              push_sample(cfg_baseline + s * amp + int'($urandom_range(0, 2 * jit)) - jit);
              left--;
            end
          end
        end
      end
    end
  endtask

  initial begin
    foreach (win_smp[i]) win_smp[i] = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_SAMPLE;
    in_ch.raw_sample = '0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale positive average, clear, near-band edge
    write_reg(REG_BASELINE, 15'(-8192));
    write_reg(REG_THRESHOLD, 15'd0);
    repeat (8) push_sample(8191);
    push_clear();
    repeat (2) push_sample(-8192);
    push_clear();
    push_sample(-8192 + 392);
    push_sample(-8192 + 8);
    drain();

    // full-scale negative average, threshold at maximum
    in_idle  = 1'b1;
    out_idle = 1'b1;
    write_reg(REG_BASELINE, 15'(8191));
    write_reg(REG_THRESHOLD, 15'd32767);
    repeat (8) push_sample(-8192);
    repeat (4) push_sample(8191);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       write_reg(REG_BASELINE, 15'($urandom_range(0, 16383)) - 15'd8192);
        1:       write_reg(REG_BASELINE, 15'(-8192));
        2:       write_reg(REG_BASELINE, 15'(8191));
        default: write_reg(REG_BASELINE, 15'd0);
      endcase
      case (p % 3)
        0:       write_reg(REG_THRESHOLD, 15'($urandom_range(0, 3000)));
        1:       write_reg(REG_THRESHOLD, 15'd0);
        default: write_reg(REG_THRESHOLD, 15'($urandom_range(0, 32767)));
      endcase
      if (p == 0) begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
      end else if (p == 1) begin
        in_idle  = 1'b1;
        out_idle = 1'b1;
      end else begin
        in_idle  = 1'($urandom_range(0, 1));
        out_idle = 1'($urandom_range(0, 1));
      end
      if (p == 3) begin
        // sink held off while the source keeps offering, then source waits for the tail
        in_idle = 1'b0;
        queue_random(150);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        drain();
        queue_random(50);
      end else begin
        queue_random(200);
      end
      drain();
    end

    // swing equal to the threshold must not count
    in_idle  = 1'b0;
    out_idle = 1'b0;
    write_reg(REG_BASELINE, 15'd0);
    write_reg(REG_THRESHOLD, 15'd1500);
    push_clear();
    repeat (10) begin
      push_sample(4000);
      push_sample(4000);
      push_sample(-8000);
    end
    drain();

    // swing one above the threshold counts on each rising crossing once the window is full
    write_reg(REG_THRESHOLD, 15'd1499);
    push_clear();
    repeat (10) begin
      push_sample(4000);
      push_sample(4000);
      push_sample(-8000);
    end
    push_clear();
    repeat (3) push_sample(int'($urandom_range(0, 16383)) - 8192);

    drain();
    repeat (8) @(posedge clk);
    mismatch_cnt += crossing_q.size();
    $display("Checked %0d words: %0d rising and %0d falling crossings, peak jump total %0d.",
             words_in, rises_seen, falls_seen, peak_total);
    $display("Baseline and threshold extremes, clears, idling, sink hold-off and threshold edges.");
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/zcj_pkg.sv
rtl/zcj_if.sv
rtl/zcj_window.sv
rtl/zcj_divider.sv
rtl/zcj_detect.sv
rtl/zero_crossing_jump_counter_unit.sv
verif/zero_crossing_jump_counter_unit_tb.sv
